@@ sv/e2q_pkg.sv @@
// shared constants and types for the euler to quaternion block
package e2q_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int OUT_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NSTG = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  typedef struct packed {
    rot_t ax;
    rot_t ay;
    rot_t az;
  } trio_t;

  function automatic logic signed [CW-1:0] atan_at(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0: r = 34'sd536870912;   1: r = 34'sd316933406;
      2: r = 34'sd167458907;   3: r = 34'sd85004756;
      4: r = 34'sd42667331;    5: r = 34'sd21354465;
      6: r = 34'sd10679838;    7: r = 34'sd5340245;
      8: r = 34'sd2670163;     9: r = 34'sd1335087;
      10: r = 34'sd667544;     11: r = 34'sd333772;
      12: r = 34'sd166886;     13: r = 34'sd83443;
      14: r = 34'sd41722;      15: r = 34'sd20861;
      16: r = 34'sd10430;      17: r = 34'sd5215;
      18: r = 34'sd2608;       19: r = 34'sd1304;
      20: r = 34'sd652;        21: r = 34'sd326;
      22: r = 34'sd163;        23: r = 34'sd81;
      24: r = 34'sd41;         25: r = 34'sd20;
      26: r = 34'sd10;         27: r = 34'sd5;
      28: r = 34'sd3;          29: r = 34'sd1;
      30: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t a, input int i);
    rot_t r;
    logic signed [CW-1:0] dx, dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (!a.z[CW-1]) begin
      r.x = a.x - dx; r.y = a.y + dy; r.z = a.z - atan_at(i);
    end else begin
      r.x = a.x + dx; r.y = a.y - dy; r.z = a.z + atan_at(i);
    end
    return r;
  endfunction
endpackage

@@ sv/e2q_cell.sv @@
// one cordic micro-rotation cell for all three angles
module e2q_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [4:0]     stage,
  input  logic           v_in,
  input  e2q_pkg::trio_t d_in,
  output logic           v_out,
  output e2q_pkg::trio_t d_out
);
  import e2q_pkg::*;
  logic v_r;
  trio_t d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_in;
    d_r.ax <= rot_step(d_in.ax, int'(stage));
    d_r.ay <= rot_step(d_in.ay, int'(stage));
    d_r.az <= rot_step(d_in.az, int'(stage));
  end
  assign v_out = v_r;
  assign d_out = d_r;
endmodule

@@ sv/e2q_product.sv @@
// hamilton product pipeline with rounding and saturation
module e2q_product (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_in,
  input  e2q_pkg::trio_t                d_in,
  output logic                          v_out,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qx,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qy,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qz,
  output logic signed [e2q_pkg::OUT_BITS-1:0] qw
);
  import e2q_pkg::*;
  localparam int SH = 62 - OUT_BITS;
  typedef logic signed [31:0] u_t;
  typedef logic signed [63:0] p_t;

  function automatic u_t clampu(input logic signed [CW-1:0] v);
    if (v > ONE_Q30) return u_t'(ONE_Q30);
    if (v < -ONE_Q30) return -u_t'(ONE_Q30);
    return u_t'(v);
  endfunction
  function automatic u_t rnd(input p_t p);
    p_t t;
    t = (p + (64'sd1 <<< 29)) >>> 30;
    return t[31:0];
  endfunction
  function automatic logic signed [OUT_BITS-1:0] sat(input p_t s);
    p_t r, mx, mn;
    r = (s + (64'sd1 <<< (SH - 1))) >>> SH;
    mx = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
    mn = -mx - 64'sd1;
    if (r > mx) r = mx;
    if (r < mn) r = mn;
    return r[OUT_BITS-1:0];
  endfunction

  logic [3:0] v_r;
  u_t cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  u_t cx2_r, sx2_r;
  u_t czcy_r, szsy_r, czsy_r, szcy_r;
  p_t t_r [8];
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[2:0], v_in};
    cx_r <= clampu(d_in.ax.x); sx_r <= clampu(d_in.ax.y);
    cy_r <= clampu(d_in.ay.x); sy_r <= clampu(d_in.ay.y);
    cz_r <= clampu(d_in.az.x); sz_r <= clampu(d_in.az.y);
    czcy_r <= rnd(p_t'(cz_r) * p_t'(cy_r));
    szsy_r <= rnd(p_t'(sz_r) * p_t'(sy_r));
    czsy_r <= rnd(p_t'(cz_r) * p_t'(sy_r));
    szcy_r <= rnd(p_t'(sz_r) * p_t'(cy_r));
    cx2_r <= cx_r; sx2_r <= sx_r;
    t_r[0] <= p_t'(czcy_r) * p_t'(sx2_r);
    t_r[1] <= p_t'(szsy_r) * p_t'(cx2_r);
    t_r[2] <= p_t'(czsy_r) * p_t'(cx2_r);
    t_r[3] <= p_t'(szcy_r) * p_t'(sx2_r);
    t_r[4] <= p_t'(szcy_r) * p_t'(cx2_r);
    t_r[5] <= p_t'(czsy_r) * p_t'(sx2_r);
    t_r[6] <= p_t'(czcy_r) * p_t'(cx2_r);
    t_r[7] <= p_t'(szsy_r) * p_t'(sx2_r);
    qx <= sat(t_r[0] - t_r[1]);
    qy <= sat(t_r[2] + t_r[3]);
    qz <= sat(t_r[4] - t_r[5]);
    qw <= sat(t_r[6] + t_r[7]);
  end
  assign v_out = v_r[3];
endmodule

@@ sv/euler_to_quaternion.sv @@
// top level: euler angles to unit quaternion, fully pipelined
// usage:
//  - drive in_angle_x/y/z and raise start; busy is always low, so an
//    item transfers at every edge with start high
//  - one result per item appears on out_quat_* with out_valid high for
//    exactly one cycle; the receiver cannot stall and must take it
//  - the path is one input register, 16 cordic
//    cells and four product stages, the last of which also saturates
//  - throughput is one item per cycle, set by the row of cordic cells
//    and the pipelined multiply chain
//  - synchronous reset clears all valid bits; items in flight are dropped
module euler_to_quaternion (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_angle_x,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_angle_y,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] in_angle_z,
  output logic out_valid,
  output logic signed [e2q_pkg::OUT_BITS-1:0] out_quat_x,
  output logic signed [e2q_pkg::OUT_BITS-1:0] out_quat_y,
  output logic signed [e2q_pkg::OUT_BITS-1:0] out_quat_z,
  output logic signed [e2q_pkg::OUT_BITS-1:0] out_quat_w
);
  import e2q_pkg::*;

  // half angle as 32-bit binary angle, sign-extended into the cordic width
  function automatic rot_t seed(input logic signed [ANGLE_BITS-1:0] a);
    rot_t r;
    logic signed [31:0] w;
    w = {a, {(32 - ANGLE_BITS){1'b0}}};
    r.x = INV_GAIN;
    r.y = '0;
    r.z = CW'(w >>> 1);
    return r;
  endfunction

  assign busy = 1'b0;

  // input register
  logic v0_r;
  trio_t d0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= start;
    d0_r.ax <= seed(in_angle_x);
    d0_r.ay <= seed(in_angle_y);
    d0_r.az <= seed(in_angle_z);
  end

  // row of cordic cells, each does one micro-rotation per cycle
  logic v_c [NSTG+1];
  trio_t d_c [NSTG+1];
  assign v_c[0] = v0_r;
  assign d_c[0] = d0_r;
  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    e2q_cell u_cell (
      .clk(clk), .rst_n(rst_n), .stage(5'(g)),
      .v_in(v_c[g]), .d_in(d_c[g]),
      .v_out(v_c[g+1]), .d_out(d_c[g+1])
    );
  end

  // product terms, rounding and saturation
  e2q_product u_prod (
    .clk(clk), .rst_n(rst_n),
    .v_in(v_c[NSTG]), .d_in(d_c[NSTG]),
    .v_out(out_valid),
    .qx(out_quat_x), .qy(out_quat_y), .qz(out_quat_z), .qw(out_quat_w)
  );
endmodule

@@ sv/e2q_checker.sv @@
// port-level checks for euler_to_quaternion, bound to the top level
module e2q_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import e2q_pkg::*;
  localparam int LAT = NSTG + 5;

  a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing");
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!start && rst_n) |-> ##LAT (!out_valid || !$past(rst_n, LAT - 1) ||
                                  !$past(rst_n, 1) || !$past(rst_n, LAT)))
    else $error("unexpected result");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

@@ tb/testbench.sv @@
// self-checking testbench for the euler to quaternion block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  // ---------------------------------------------------------------------------
  // quaternion predictor and expectation store
  // ---------------------------------------------------------------------------
  typedef struct {
    logic signed [OUT_BITS-1:0] qx, qy, qz, qw;
  } quat_t;

  class quat_scoreboard;
    quat_t pending[$];
    int errors;
    int checked;
    longint atan_tab[32];

    function new();
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                   83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                   81, 41, 20, 10, 5, 3, 1, 1, 0};
      errors = 0;
      checked = 0;
    endfunction

    // widen the binary angle to 2^31 = pi, then halve
    function longint halve(logic [ANGLE_BITS-1:0] a);
      logic signed [31:0] w;
      w = {a, {(32-ANGLE_BITS){1'b0}}};
      return longint'(w) >>> 1;
    endfunction

    function longint clamp1(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
    endfunction

    function void sincos(longint ang, output longint c, output longint s);
      longint xr, yr, dx, dy;
      xr = 652032874;
      yr = 0;
      for (int i = 0; i < NSTG; i++) begin
        dx = yr >>> i;
        dy = xr >>> i;
        if (ang >= 0) begin
          xr -= dx; yr += dy; ang -= atan_tab[i];
        end else begin
          xr += dx; yr -= dy; ang += atan_tab[i];
        end
      end
      c = clamp1(xr);
      s = clamp1(yr);
    endfunction

    function longint prod3(longint a, longint b, longint c);
      longint ab;
      ab = (a * b + (64'sd1 << 29)) >>> 30;
      return ab * c;
    endfunction

    function logic signed [OUT_BITS-1:0] to_q14(longint sum);
      longint r, hi, lo;
      hi = (64'sd1 << (OUT_BITS-1)) - 1;
      lo = -hi - 1;
      r = (sum + (64'sd1 << (62-OUT_BITS-1))) >>> (62-OUT_BITS);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[OUT_BITS-1:0];
    endfunction

    // note an accepted input transfer
    function void note_angles(logic [ANGLE_BITS-1:0] ax, ay, az);
      longint cx, sx, cy, sy, cz, sz;
      quat_t q;
      sincos(halve(ax), cx, sx);
      sincos(halve(ay), cy, sy);
      sincos(halve(az), cz, sz);
      q.qx = to_q14(prod3(cz, cy, sx) - prod3(sz, sy, cx));
      q.qy = to_q14(prod3(cz, sy, cx) + prod3(sz, cy, sx));
      q.qz = to_q14(prod3(sz, cy, cx) - prod3(cz, sy, sx));
      q.qw = to_q14(prod3(cz, cy, cx) + prod3(sz, sy, sx));
      pending.push_back(q);
    endfunction

    // check one result transfer against the oldest expectation
    function void check_quat(quat_t got);
      quat_t exp_q;
      if (pending.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d w=%0d",
               got.qx, got.qy, got.qz, got.qw);
        errors++;
        return;
      end
      exp_q = pending.pop_front();
      checked++;
      if (got.qx !== exp_q.qx) begin
        $error("quat_x expected %0d actual %0d", exp_q.qx, got.qx); errors++;
      end
      if (got.qy !== exp_q.qy) begin
        $error("quat_y expected %0d actual %0d", exp_q.qy, got.qy); errors++;
      end
      if (got.qz !== exp_q.qz) begin
        $error("quat_z expected %0d actual %0d", exp_q.qz, got.qz); errors++;
      end
      if (got.qw !== exp_q.qw) begin
        $error("quat_w expected %0d actual %0d", exp_q.qw, got.qw); errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, dut
  // ---------------------------------------------------------------------------
  localparam int LATENCY = CORDIC_STAGES + 6;
  localparam int STALL_LIMIT = 2000;   // idle cycles with no transfer before giving up

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [ANGLE_BITS-1:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic out_valid;
  logic signed [OUT_BITS-1:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;

  always #5 clk = ~clk;

  euler_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w)
  );

  quat_scoreboard board = new();
  int sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;   // set during the stretch with no idling

  // ---------------------------------------------------------------------------
  // monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    quat_t got;
    if (rst_n) begin
      if (start && !busy) begin
        board.note_angles(in_angle_x, in_angle_y, in_angle_z);
        sent++;
      end
      if (out_valid) begin
        got.qx = out_quat_x; got.qy = out_quat_y;
        got.qz = out_quat_z; got.qw = out_quat_w;
        board.check_quat(got);
      end
      // watchdog on cycles with neither transfer
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("euler_to_quaternion: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver tasks
  // ---------------------------------------------------------------------------
  // offer one angle triple, with random idle cycles before it; waits for the
  // transfer, start stays high into the next item if it follows back to back
  task automatic send_angles(input logic [ANGLE_BITS-1:0] ax, ay, az);
    while (!no_gaps && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // hold off the sender until every expected result has come
  task automatic drain_results();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  // angles near the interesting points (axes, +-pi, +-pi/2, pi/4) with jitter, or fully random
  function automatic logic [ANGLE_BITS-1:0] pick_angle();
    logic [ANGLE_BITS-1:0] base;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(5))
          0: base = 16'h8000;
          1: base = 16'h7fff;
          2: base = 16'h4000;
          3: base = 16'hc000;
          4: base = 16'h0000;
          default: base = 16'h2000;
        endcase
        return base + ANGLE_BITS'($urandom_range(8)) - ANGLE_BITS'(4);
      end
      default: return ANGLE_BITS'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [ANGLE_BITS-1:0] corner[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                       16'h4000, 16'hc000, 16'h0001, 16'h2000};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: single-axis extremes, minus pi on every axis, all-extreme mixes
    for (int i = 0; i < 8; i++) send_angles(corner[i], '0, '0);
    for (int i = 0; i < 4; i++) send_angles('0, corner[i], '0);
    for (int i = 0; i < 4; i++) send_angles('0, '0, corner[i]);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'h7fff, 16'h7fff, 16'h7fff);
    send_angles(16'h4000, 16'h4000, 16'h4000);
    send_angles(16'hc000, 16'h4000, 16'h8000);
    send_angles(16'haaaa, 16'h5555, 16'haaaa);
    send_angles(16'h5555, 16'haaaa, 16'h5555);

    // pause until the pipeline has emptied
    drain_results();

    // random part; a stretch in the middle runs without any gaps
    for (int n = 0; n < 1330; n++) begin
      no_gaps = (n >= 400 && n < 600);
      if (n == 900) drain_results();
      if ($urandom_range(1)) send_angles(pick_angle(), pick_angle(), pick_angle());
      else send_angles(ANGLE_BITS'($urandom), ANGLE_BITS'($urandom),
                       ANGLE_BITS'($urandom));
    end
    start <= 1'b0;

    // wait for the tail, then keep watching for stray results
    while (board.pending.size() != 0) @(negedge clk);
    repeat (3 * LATENCY) @(negedge clk);

    $display("sent %0d angle triples (extremes, minus pi, random and near-axis),",
             sent);
    $display("checked %0d quaternions across gaps, back-to-back and drained pipes",
             board.checked);
    if (board.errors == 0)
      $display("euler_to_quaternion: match");
    else
      $display("euler_to_quaternion: mismatch");
    $finish;
  end
endmodule

@@ euler_to_quaternion.f @@
sv/e2q_pkg.sv
sv/e2q_cell.sv
sv/e2q_product.sv
sv/euler_to_quaternion.sv
sv/e2q_checker.sv
tb/testbench.sv
